// ----- rtl/prra_pkg.sv -----
// Shared types and constants for the pro-rata allocator.
package prra_pkg;

  localparam int QTY_BITS       = 48;
  localparam int SHARE_W        = QTY_BITS - 1;
  localparam int ORDER_W        = 6;
  localparam int MAX_ORDERS_DEF = 64;
  // need sum over up to 64 orders
  localparam int SUM_W          = QTY_BITS + 7;
  localparam int PROD_W         = 2 * SHARE_W;

  typedef struct packed {
    logic signed [QTY_BITS-1:0] need_qty;
    logic signed [QTY_BITS-1:0] pool_qty;
    logic                       last_item;
  } ord_beat_t;

  typedef struct packed {
    logic [SHARE_W-1:0] share_qty;
    logic [ORDER_W-1:0] order_index;
    logic               last_share;
  } alloc_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_EVAL,
    ST_WAIT,
    ST_CLIP,
    ST_SEND
  } st_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic               start;
    logic [SHARE_W-1:0] a;
    logic [SHARE_W-1:0] b;
    logic [SUM_W-1:0]   d;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [SHARE_W-1:0] q;
  } md_rsp_t;

endpackage

// ----- rtl/pro_rata_allocator.sv -----
// Pro-rata allocator top level: need memory, batch sequencer and share clipping.
// Sequence: a beat without the last mark is only stored. After the last beat each order
// is read and evaluated; an inactive one then goes to send, the last active one to clip
// and send, and any other first waits for the multiply steps and divide steps of the
// shared mul/div unit. Throughput: one order beat per cycle while loading; no input is
// taken while shares are being delivered, and an output stall holds the share beat.
// Reset: synchronous, clears counts, sums and sequencer; need memory is not cleared.
module pro_rata_allocator #(
  parameter int MAX_ORDERS = prra_pkg::MAX_ORDERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ord_valid,
  output logic                  ord_stall,
  input  prra_pkg::ord_beat_t   ord_data,
  output logic                  alloc_valid,
  input  logic                  alloc_stall,
  output prra_pkg::alloc_beat_t alloc_data
);
  import prra_pkg::*;

  localparam int CNT_W = $clog2(MAX_ORDERS + 1);
  localparam int IDX_W = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;

  st_t                state, state_next;
  logic [QTY_BITS-1:0] mem [MAX_ORDERS];
  logic [QTY_BITS-1:0] rd_data;
  logic [CNT_W-1:0]   loaded_count, loaded_count_next;
  logic [CNT_W-1:0]   active_count, active_count_next;
  logic [CNT_W-1:0]   seen, seen_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [SUM_W-1:0]   need_sum, need_sum_next;
  logic [SHARE_W-1:0] amount_left, amount_left_next;
  logic [SHARE_W-1:0] cand, cand_next;
  alloc_beat_t        out_reg, out_reg_next;
  md_req_t            md_req;
  md_rsp_t            md_rsp;

  logic               ord_fire;
  logic               store_en;
  logic               in_pos;
  logic               tot_pos;
  logic               need_pos;
  logic               last_active;
  logic               last_order;
  logic [SHARE_W-1:0] need_val;
  logic [SHARE_W-1:0] share_c;
  logic [CNT_W-1:0]   seen_inc;

  prra_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign ord_fire    = ord_valid && !ord_stall;
  assign store_en    = ord_fire && (loaded_count < CNT_W'(MAX_ORDERS));
  assign in_pos      = !ord_data.need_qty[QTY_BITS-1] && (ord_data.need_qty != '0);
  assign tot_pos     = !ord_data.pool_qty[QTY_BITS-1] && (ord_data.pool_qty != '0);
  assign need_pos    = !rd_data[QTY_BITS-1] && (rd_data != '0);
  assign need_val    = rd_data[SHARE_W-1:0];
  assign seen_inc    = seen + CNT_W'(1);
  assign last_active = (seen_inc == active_count);
  assign last_order  = ((idx + CNT_W'(1)) == loaded_count);
  assign share_c     = (cand > amount_left) ? amount_left : cand;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (ord_fire && ord_data.last_item) state_next = ST_READ;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (!need_pos) begin
          state_next = ST_SEND;
        end else if (last_active) begin
          state_next = ST_CLIP;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: if (md_rsp.done) state_next = ST_CLIP;
      ST_CLIP: state_next = ST_SEND;
      ST_SEND: if (!alloc_stall) state_next = last_order ? ST_LOAD : ST_READ;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    ord_stall    = (state != ST_LOAD);
    alloc_valid  = (state == ST_SEND);
    alloc_data   = out_reg;
    md_req.start = (state == ST_EVAL) && need_pos && !last_active;
    md_req.a     = need_val;
    md_req.b     = amount_left;
    md_req.d     = need_sum;
  end

  always_comb begin
    loaded_count_next = loaded_count;
    active_count_next = active_count;
    seen_next         = seen;
    idx_next          = idx;
    need_sum_next     = need_sum;
    amount_left_next  = amount_left;
    cand_next         = cand;
    out_reg_next      = out_reg;
    unique case (state)
      ST_LOAD: begin
        if (store_en) begin
          loaded_count_next = loaded_count + CNT_W'(1);
          if (in_pos) begin
            need_sum_next     = need_sum + SUM_W'(ord_data.need_qty[SHARE_W-1:0]);
            active_count_next = active_count + CNT_W'(1);
          end
        end
        if (ord_fire && ord_data.last_item) begin
          amount_left_next = tot_pos ? ord_data.pool_qty[SHARE_W-1:0] : '0;
          idx_next         = '0;
          seen_next        = '0;
        end
      end
      ST_READ: begin
      end
      ST_EVAL: begin
        out_reg_next.share_qty   = '0;
        out_reg_next.order_index = ORDER_W'(idx);
        out_reg_next.last_share  = last_order;
        if (need_pos) begin
          seen_next = seen_inc;
          if (last_active) begin
            cand_next = (amount_left < need_val) ? amount_left : need_val;
          end
        end
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          cand_next = (md_rsp.q > need_val) ? need_val : md_rsp.q;
        end
      end
      ST_CLIP: begin
        out_reg_next.share_qty = share_c;
        if (share_c != '0) begin
          amount_left_next = amount_left - share_c;
          need_sum_next    = need_sum - SUM_W'(need_val);
        end
      end
      ST_SEND: begin
        if (!alloc_stall) begin
          if (last_order) begin
            loaded_count_next = '0;
            active_count_next = '0;
            need_sum_next     = '0;
            amount_left_next  = '0;
          end else begin
            idx_next = idx + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      loaded_count <= '0;
      active_count <= '0;
      seen         <= '0;
      idx          <= '0;
      need_sum     <= '0;
      amount_left  <= '0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      active_count <= active_count_next;
      seen         <= seen_next;
      idx          <= idx_next;
      need_sum     <= need_sum_next;
      amount_left  <= amount_left_next;
    end
    cand    <= cand_next;
    out_reg <= out_reg_next;
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[loaded_count[IDX_W-1:0]] <= ord_data.need_qty;
    end
    rd_data <= mem[idx[IDX_W-1:0]];
  end

endmodule

// ----- rtl/prra_muldiv.sv -----
// Iterative a*b/d unit: shift-add multiply, then restoring divide, one bit a cycle.
module prra_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  prra_pkg::md_req_t req,
  output prra_pkg::md_rsp_t rsp
);
  import prra_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  md_state_t          state, state_next;
  logic [PROD_W-1:0]  acc, acc_next;
  logic [SHARE_W-1:0] mplier, mplier_next;
  logic [SHARE_W-1:0] mcand, mcand_next;
  logic [SUM_W-1:0]   divisor, divisor_next;
  logic [SUM_W-1:0]   rem, rem_next;
  logic [SHARE_W-1:0] quo, quo_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [SUM_W:0]     trial;
  logic               fits;

  assign trial = {rem, acc[PROD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (req.start) state_next = (req.d == '0) ? MD_DONE : MD_MUL;
      MD_MUL:  if (cnt == '0) state_next = MD_DIV;
      MD_DIV:  if (cnt == '0) state_next = MD_DONE;
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_comb begin
    acc_next     = acc;
    mplier_next  = mplier;
    mcand_next   = mcand;
    divisor_next = divisor;
    rem_next     = rem;
    quo_next     = quo;
    cnt_next     = cnt;
    unique case (state)
      MD_IDLE: begin
        if (req.start) begin
          mplier_next  = req.a;
          mcand_next   = req.b;
          divisor_next = req.d;
          acc_next     = '0;
          quo_next     = '0;
          cnt_next     = CNT_W'(SHARE_W - 1);
        end
      end
      MD_MUL: begin
        acc_next    = (acc << 1) +
                      (mplier[SHARE_W-1] ? {{SHARE_W{1'b0}}, mcand} : {PROD_W{1'b0}});
        mplier_next = mplier << 1;
        cnt_next    = cnt - CNT_W'(1);
        if (cnt == '0) begin
          cnt_next = CNT_W'(PROD_W - 1);
          rem_next = '0;
        end
      end
      MD_DIV: begin
        acc_next = acc << 1;
        quo_next = {quo[SHARE_W-2:0], fits};
        rem_next = fits ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
        cnt_next = cnt - CNT_W'(1);
      end
      MD_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.done = (state == MD_DONE);
    rsp.q    = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
    acc     <= acc_next;
    mplier  <= mplier_next;
    mcand   <= mcand_next;
    divisor <= divisor_next;
    rem     <= rem_next;
    quo     <= quo_next;
    cnt     <= cnt_next;
  end

endmodule

// ----- rtl/prra_checker.sv -----
// Port-level checks for the pro-rata allocator, bound to the top level.
module prra_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  ord_valid,
  input logic                  ord_stall,
  input prra_pkg::ord_beat_t   ord_data,
  input logic                  alloc_valid,
  input logic                  alloc_stall,
  input prra_pkg::alloc_beat_t alloc_data
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !alloc_valid)
    else $error("share beat right after reset");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    alloc_valid |-> ord_stall)
    else $error("order beat accepted while shares are pending");

  a_batch_end: assert property (@(posedge clk) disable iff (rst)
    alloc_valid && !alloc_stall && alloc_data.last_share |=> !alloc_valid && !ord_stall)
    else $error("block not back to loading after last share");

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    ord_valid && !ord_stall && !ord_data.last_item |=> !alloc_valid && !ord_stall)
    else $error("unmarked order beat caused output or stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    alloc_valid && alloc_stall |=> alloc_valid && $stable(alloc_data))
    else $error("stalled share beat changed");

endmodule

bind pro_rata_allocator prra_checker u_prra_checker (.*);

// ----- verif/pro_rata_allocator_test.sv -----
// Self-checking testbench for pro_rata_allocator: directed table, random batches, share predictor.
module pro_rata_allocator_test;
  import prra_pkg::*;

  localparam int MAX_ORDERS = MAX_ORDERS_DEF;
  localparam int ITEMS = 430;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam logic [QTY_BITS-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [QTY_BITS-1:0] Q_MIN = 48'h8000_0000_0000;
  localparam logic [SHARE_W-1:0] S_MAX = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [QTY_BITS-1:0] need;
    logic [QTY_BITS-1:0] total;
    logic                last;
    logic                pinned;
    logic [SHARE_W-1:0]  share;
  } plan_row_t;

  // pinned rows carry a share that is obvious by hand; the rest use the predictor
  localparam int PLAN_LEN = 21;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{48'd10, 48'd4, 1'b1, 1'b1, 47'd4},
    '{48'd0, 48'd0, 1'b0, 1'b1, 47'd0},
    '{Q_MIN, 48'd0, 1'b0, 1'b1, 47'd0},
    '{-48'sd1, 48'd0, 1'b0, 1'b1, 47'd0},
    '{Q_MAX, Q_MAX, 1'b1, 1'b1, S_MAX},
    '{48'd100, 48'd0, 1'b0, 1'b1, 47'd0},
    '{48'd200, 48'd0, 1'b1, 1'b1, 47'd0},
    '{48'd5, Q_MIN, 1'b1, 1'b1, 47'd0},
    '{48'd7, 48'd0, 1'b0, 1'b1, 47'd0},
    '{48'd9, -48'sd1, 1'b1, 1'b1, 47'd0},
    '{48'd0, 48'd50, 1'b0, 1'b1, 47'd0},
    '{-48'sd3, 48'd50, 1'b1, 1'b1, 47'd0},
    '{48'd30, 48'd0, 1'b0, 1'b0, 47'd0},
    '{48'd70, 48'd50, 1'b1, 1'b0, 47'd0},
    '{48'd1, 48'd0, 1'b0, 1'b0, 47'd0},
    '{48'd1, 48'd0, 1'b0, 1'b0, 47'd0},
    '{48'd1, 48'd2, 1'b1, 1'b0, 47'd0},
    '{48'd5, 48'd0, 1'b0, 1'b0, 47'd0},
    '{48'd8, 48'd1000, 1'b1, 1'b0, 47'd0},
    '{48'd20, 48'd12345, 1'b0, 1'b0, 47'd0},
    '{48'd20, 48'd10, 1'b1, 1'b0, 47'd0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        ord_valid = 1'b0;
  logic        ord_stall;
  ord_beat_t   ord_data = '0;
  logic        alloc_valid;
  logic        alloc_stall = 1'b0;
  alloc_beat_t alloc_data;

  pro_rata_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .ord_valid  (ord_valid),
    .ord_stall  (ord_stall),
    .ord_data   (ord_data),
    .alloc_valid(alloc_valid),
    .alloc_stall(alloc_stall),
    .alloc_data (alloc_data)
  );

  // predictor state
  logic [QTY_BITS-1:0] need_mem [MAX_ORDERS];
  int                  n_loaded = 0;
  int                  n_active = 0;
  logic [63:0]         need_total = '0;
  bit                  pin_ok [MAX_ORDERS];
  logic [SHARE_W-1:0]  pin_val [MAX_ORDERS];
  alloc_beat_t         pending_shares [$];

  int errors = 0;
  int n_sent = 0;
  int n_batches = 0;
  int n_over = 0;
  int n_dropped = 0;
  int shares_checked = 0;
  int gap_pct = 25;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_left = 0;
  int stall_roll = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit is_pos(logic [QTY_BITS-1:0] v);
    return v != '0 && !v[QTY_BITS-1];
  endfunction

  // book one accepted beat; on the last mark, queue the batch's shares
  task automatic load_and_allocate(input ord_beat_t b);
    logic [QTY_BITS-1:0] need;
    logic [QTY_BITS-1:0] amount;
    logic [63:0]         left;
    logic [63:0]         share;
    logic [63:0]         quot;
    logic [127:0]        prod;
    int                  seen;
    alloc_beat_t         r;
    need = b.need_qty;
    amount = b.pool_qty;
    if (n_loaded < MAX_ORDERS) begin
      need_mem[n_loaded] = need;
      n_loaded++;
      if (is_pos(need)) begin
        need_total += 64'(need);
        n_active++;
      end
    end else begin
      n_dropped++;
    end
    if (!b.last_item) return;
    left = is_pos(amount) ? 64'(amount) : '0;
    seen = 0;
    for (int i = 0; i < n_loaded; i++) begin
      need = need_mem[i];
      share = '0;
      if (is_pos(need)) begin
        seen++;
        if (seen != n_active) begin
          prod = 128'(need) * 128'(left);
          quot = (need_total == '0) ? '0 : 64'(prod / 128'(need_total));
          share = (quot > 64'(need)) ? 64'(need) : quot;
        end else begin
          share = (left < 64'(need)) ? left : 64'(need);
        end
        if (share > left) share = left;
        if (share != '0) begin
          left -= share;
          need_total -= 64'(need);
        end
      end
      r.share_qty = pin_ok[i] ? pin_val[i] : share[SHARE_W-1:0];
      r.order_index = i[ORDER_W-1:0];
      r.last_share = (i + 1 == n_loaded);
      pending_shares = {pending_shares, r};
    end
    if (n_dropped != 0) n_over++;
    n_batches++;
    n_loaded = 0;
    n_active = 0;
    n_dropped = 0;
    need_total = '0;
    pin_ok = '{default: 1'b0};
  endtask

  task automatic send_beat(input ord_beat_t b);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      ord_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    ord_valid <= 1'b1;
    ord_data <= b;
    @(posedge clk);
    while (ord_stall) @(posedge clk);
    load_and_allocate(b);
    n_sent++;
  endtask

  function automatic logic [QTY_BITS-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[QTY_BITS-1:0];
  endfunction

  function automatic logic [QTY_BITS-1:0] rand_need(bit big);
    case ($urandom_range(0, 9))
      0: return rand48();
      1: return '0;
      2: return -48'($urandom_range(1, 1000));
      3: return Q_MAX - 48'($urandom_range(0, 3));
      default: return big ? rand48() >> 1 : 48'($urandom_range(1, 100000));
    endcase
  endfunction

  function automatic logic [QTY_BITS-1:0] rand_total(bit big, int size);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return Q_MIN | rand48();
      2: return rand48();
      3: return Q_MAX;
      default: return big ? rand48() >> 1 : 48'($urandom_range(1, 200000 * size));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || calm) begin
      alloc_stall <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
    end else begin
      if (stall_left == 0 && quiet_left == 0) begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 10) stall_left = $urandom_range(1, 6);
        else if (stall_roll < 12) quiet_left = $urandom_range(40, 300);
      end
      if (quiet_left > 0) quiet_left--;
      alloc_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : share_check
    alloc_beat_t want;
    if (!rst && alloc_valid && !alloc_stall) begin
      if (pending_shares.size() == 0) begin
        $display("%0t: unexpected share beat: share %0d order %0d last %0b", $time,
                 alloc_data.share_qty, alloc_data.order_index, alloc_data.last_share);
        errors++;
      end else begin
        want = pending_shares.pop_front();
        shares_checked++;
        if (alloc_data.share_qty !== want.share_qty ||
            alloc_data.order_index !== want.order_index ||
            alloc_data.last_share !== want.last_share) begin
          $display("%0t: expected share %0d order %0d last %0b, got share %0d order %0d last %0b",
                   $time, want.share_qty, want.order_index, want.last_share,
                   alloc_data.share_qty, alloc_data.order_index, alloc_data.last_share);
          errors++;
        end
      end
    end
  end

  initial begin
    ord_beat_t b;
    int        size;
    int        pick;
    bit        big;
    pin_ok = '{default: 1'b0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      pin_ok[n_loaded] = PLAN[r].pinned;
      pin_val[n_loaded] = PLAN[r].share;
      b.need_qty = PLAN[r].need;
      b.pool_qty = PLAN[r].total;
      b.last_item = PLAN[r].last;
      send_beat(b);
    end

    while (n_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (n_over == 0 && n_sent > 40) size = MAX_ORDERS + 2;
      else if (pick < 65) size = $urandom_range(1, 6);
      else if (pick < 88) size = $urandom_range(7, 16);
      else if (pick < 98) size = $urandom_range(17, MAX_ORDERS);
      else size = $urandom_range(MAX_ORDERS + 1, MAX_ORDERS + 6);
      if (size > ITEMS - n_sent) size = ITEMS - n_sent;
      big = $urandom_range(0, 2) == 0;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      for (int k = 0; k < size; k++) begin
        b.need_qty = rand_need(big);
        b.last_item = (k == size - 1);
        b.pool_qty = b.last_item ? rand_total(big, size) : rand48();
        send_beat(b);
      end
      if (n_sent >= ITEMS - 40) calm = 1'b1;
    end

    ord_valid <= 1'b0;
    while (pending_shares.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d order beats in %0d batches, %0d of them over-length.",
             n_sent, n_batches, n_over);
    $display("Checked %0d shares; %0d mismatches.", shares_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/prra_pkg.sv
rtl/prra_muldiv.sv
rtl/pro_rata_allocator.sv
rtl/prra_checker.sv
verif/pro_rata_allocator_test.sv
